@@ rtl/pcr_pkg.sv @@
`default_nettype none

package pcr_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // configuration space
   localparam int                 CSR_AW           = 2;
   localparam logic [CSR_AW-1:0]  ADDR_RESTITUTION = '0;
   localparam logic [15:0]        RESTITUTION_RST  = 16'h8000;

   localparam int IN_DATA_W  = 288;
   localparam int OUT_DATA_W = 384;

   // isqrt of a 64-bit radicand, one result bit per stage
   localparam int SQRT_STEPS = 32;

   // datapath widths that do not depend on the fraction width
   localparam int S_W = 34;  // separating speed
   localparam int K_W = 36;  // scaled impulse magnitude, also vs
   localparam int P_W = 33;  // depth along the normal

   typedef struct packed {
      logic             is_floor;
      logic [2:0]       neg;
      logic [2:0][31:0] mag;
      logic [2:0][31:0] vel;
      logic [31:0]      inv_a;
      logic [31:0]      inv_b;
      logic [32:0]      mass_sum;
      logic [31:0]      depth;
   } geom_type;

   typedef struct packed {
      logic             is_floor;
      logic             degen;
      logic [2:0]       neg;
      logic [2:0][31:0] vel;
      logic [31:0]      depth;
   } back_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      logic [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/pcr_front.sv @@
`default_nettype none

module pcr_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic                    in_is_floor,
   input  logic [2:0][31:0]        in_pos,
   input  logic [2:0][31:0]        in_vel,
   input  logic [31:0]             in_inv_a,
   input  logic [31:0]             in_inv_b,
   input  logic [31:0]             in_depth,
   output logic                    out_valid,
   output pcr_pkg::geom_type       out_geom,
   output logic [63:0]             out_sq_sum
);

   logic [2:0]        v_ff;

   logic              fl1_ff;
   logic [2:0][31:0]  pos1_ff;
   logic [2:0][31:0]  vel1_ff;
   logic [31:0]       ia1_ff;
   logic [31:0]       ib1_ff;
   logic [31:0]       dep1_ff;

   pcr_pkg::geom_type g2_in, g2_ff, g3_ff;
   logic [2:0][63:0]  sq2_in, sq2_ff;
   logic [63:0]       sq3_ff;

   always_comb begin
      g2_in          = '0;
      g2_in.is_floor = fl1_ff;
      g2_in.vel      = vel1_ff;
      g2_in.inv_a    = ia1_ff;
      g2_in.inv_b    = ib1_ff;
      g2_in.mass_sum = {1'b0, ia1_ff} + {1'b0, ib1_ff};
      g2_in.depth    = dep1_ff;
      for (int i = 0; i < 3; i++) begin
         g2_in.neg[i] = pos1_ff[i][31];
         g2_in.mag[i] = pos1_ff[i][31] ? (~pos1_ff[i] + 32'd1) : pos1_ff[i];
         sq2_in[i]    = 64'(g2_in.mag[i]) * 64'(g2_in.mag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fl1_ff  <= in_is_floor;
         pos1_ff <= in_pos;
         vel1_ff <= in_vel;
         ia1_ff  <= in_inv_a;
         ib1_ff  <= in_inv_b;
         dep1_ff <= in_depth;
         g2_ff   <= g2_in;
         sq2_ff  <= sq2_in;
         g3_ff   <= g2_ff;
         sq3_ff  <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
      end
   end

   assign out_valid  = v_ff[2];
   assign out_geom   = g3_ff;
   assign out_sq_sum = sq3_ff;

endmodule

`default_nettype wire

@@ rtl/pcr_isqrt.sv @@
`default_nettype none

module pcr_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [63:0]       in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [31:0]       out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int STEPS = pcr_pkg::SQRT_STEPS;

   logic [STEPS-1:0]  v_ff;
   logic [63:0]       rem_ff  [STEPS];
   logic [63:0]       res_ff  [STEPS];
   logic [SIDE_W-1:0] side_ff [STEPS];
   logic [63:0]       rem_src [STEPS];
   logic [63:0]       res_src [STEPS];
   logic [63:0]       rem_in  [STEPS];
   logic [63:0]       res_in  [STEPS];

   // one digit per stage, trial bit walks down from 2^62
   always_comb begin
      logic [63:0] bit_c;
      logic [63:0] trial;
      rem_src[0] = in_rad;
      res_src[0] = '0;
      for (int i = 1; i < STEPS; i++) begin
         rem_src[i] = rem_ff[i-1];
         res_src[i] = res_ff[i-1];
      end
      for (int i = 0; i < STEPS; i++) begin
         bit_c = 64'd1 << (62 - 2 * i);
         trial = res_src[i] + bit_c;
         if (rem_src[i] >= trial) begin
            rem_in[i] = rem_src[i] - trial;
            res_in[i] = (res_src[i] >> 1) + bit_c;
         end else begin
            rem_in[i] = rem_src[i];
            res_in[i] = res_src[i] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < STEPS; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         for (int i = 0; i < STEPS; i++) begin
            rem_ff[i] <= rem_in[i];
            res_ff[i] <= res_in[i];
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_root  = res_ff[STEPS-1][31:0];
   assign out_side  = side_ff[STEPS-1];

endmodule

`default_nettype wire

@@ rtl/pcr_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per stage. The quotient must fit in QW bits,
// so the upper dividend bits start out below the divisor.
module pcr_div #(
   parameter int LANES  = 1,
   parameter int DW     = 48,
   parameter int VW     = 33,
   parameter int QW     = 17,
   parameter int SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [LANES-1:0][DW-1:0]    in_num,
   input  logic [LANES-1:0][VW-1:0]    in_den,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [LANES-1:0][QW-1:0]    out_quo,
   output logic [SIDE_W-1:0]           out_side
);

   localparam int RW = VW + 1;

   logic [QW-1:0]     v_ff;
   logic [SIDE_W-1:0] side_ff [QW];
   logic [RW-1:0]     rem_ff  [QW][LANES];
   logic [QW-1:0]     lo_ff   [QW][LANES];
   logic [QW-1:0]     quo_ff  [QW][LANES];
   logic [VW-1:0]     den_ff  [QW][LANES];

   logic [RW-1:0]     rem_src [QW][LANES];
   logic [QW-1:0]     lo_src  [QW][LANES];
   logic [QW-1:0]     quo_src [QW][LANES];
   logic [VW-1:0]     den_src [QW][LANES];
   logic [RW-1:0]     rem_in  [QW][LANES];
   logic [QW-1:0]     lo_in   [QW][LANES];
   logic [QW-1:0]     quo_in  [QW][LANES];

   always_comb begin
      logic [RW-1:0] t;
      for (int l = 0; l < LANES; l++) begin
         rem_src[0][l] = RW'(in_num[l] >> QW);
         lo_src[0][l]  = in_num[l][QW-1:0];
         quo_src[0][l] = '0;
         den_src[0][l] = in_den[l];
      end
      for (int j = 1; j < QW; j++) begin
         for (int l = 0; l < LANES; l++) begin
            rem_src[j][l] = rem_ff[j-1][l];
            lo_src[j][l]  = lo_ff[j-1][l];
            quo_src[j][l] = quo_ff[j-1][l];
            den_src[j][l] = den_ff[j-1][l];
         end
      end
      for (int j = 0; j < QW; j++) begin
         for (int l = 0; l < LANES; l++) begin
            t = {rem_src[j][l][RW-2:0], lo_src[j][l][QW-1]};
            lo_in[j][l] = lo_src[j][l] << 1;
            if (t >= {1'b0, den_src[j][l]}) begin
               rem_in[j][l] = t - {1'b0, den_src[j][l]};
               quo_in[j][l] = {quo_src[j][l][QW-2:0], 1'b1};
            end else begin
               rem_in[j][l] = t;
               quo_in[j][l] = {quo_src[j][l][QW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[QW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int j = 1; j < QW; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
         for (int j = 0; j < QW; j++) begin
            for (int l = 0; l < LANES; l++) begin
               rem_ff[j][l] <= rem_in[j][l];
               lo_ff[j][l]  <= lo_in[j][l];
               quo_ff[j][l] <= quo_in[j][l];
               den_ff[j][l] <= den_src[j][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = quo_ff[QW-1][l];
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

`default_nettype wire

@@ rtl/pcr_back.sv @@
`default_nettype none

module pcr_back #(
   parameter int FRAC_BITS = pcr_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  pcr_pkg::back_type                in_side,
   input  logic [2:0][FRAC_BITS:0]          in_nq,
   input  logic [FRAC_BITS:0]               in_ra,
   input  logic [FRAC_BITS:0]               in_rb,
   input  logic [15:0]                      restitution,
   output logic                             out_valid,
   output logic [pcr_pkg::OUT_DATA_W-1:0]   out_data
);

   localparam int QW     = FRAC_BITS + 1;
   localparam int NW     = FRAC_BITS + 2;
   localparam int VNW    = 32 + NW;
   localparam int SUMW   = VNW + 2;
   localparam int ESW    = pcr_pkg::S_W + 17;
   localparam int RPW    = NW + pcr_pkg::P_W;
   localparam int KNW    = pcr_pkg::K_W + NW;
   localparam int STAGES = 9;
   localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

   logic [STAGES-1:0] v_ff;

   // stage 1: signed normal and mass ratios, floor/degenerate overrides
   logic signed [NW-1:0]     n1_in [3], n1_ff [3];
   logic [QW-1:0]            ra1_in, rb1_in, ra1_ff, rb1_ff;
   logic                     fl1_ff;
   logic [2:0][31:0]         vel1_ff;
   logic [31:0]              dep1_ff;
   // stage 2: v*n and depth*n
   logic signed [VNW-1:0]    pv2_ff [3], pd2_ff [3];
   logic signed [NW-1:0]     n2_ff [3];
   logic [QW-1:0]            ra2_ff, rb2_ff;
   logic                     fl2_ff;
   logic [31:0]              vz2_ff;
   // stage 3: separating speed, depth along normal
   logic signed [pcr_pkg::S_W-1:0] s3_in, s3_ff;
   logic signed [pcr_pkg::P_W-1:0] p3_ff [3];
   logic signed [NW-1:0]     n3_ff [3];
   logic [QW-1:0]            ra3_ff, rb3_ff;
   // stage 4: e*s, ratio*p
   logic signed [ESW-1:0]    es4_ff;
   logic signed [RPW-1:0]    pa4_ff [3], pb4_ff [3];
   logic signed [NW-1:0]     n4_ff [3];
   logic [QW-1:0]            ra4_ff, rb4_ff;
   // stage 5: k, position outputs
   logic signed [pcr_pkg::K_W-1:0] k5_ff;
   logic [31:0]              dpa5_ff [3], dpb5_ff [3];
   logic signed [NW-1:0]     n5_ff [3];
   logic [QW-1:0]            ra5_ff, rb5_ff;
   // stage 6: k*n
   logic signed [KNW-1:0]    kn6_ff [3];
   logic [QW-1:0]            ra6_ff, rb6_ff;
   logic [31:0]              dpa6_ff [3], dpb6_ff [3];
   // stage 7: vs
   logic signed [pcr_pkg::K_W-1:0] vs7_ff [3];
   logic [QW-1:0]            ra7_ff, rb7_ff;
   logic [31:0]              dpa7_ff [3], dpb7_ff [3];
   // stage 8: ratio*vs
   logic signed [RPW+3:0]    av8_ff [3], bv8_ff [3];
   logic [31:0]              dpa8_ff [3], dpb8_ff [3];
   // stage 9: result register
   logic [11:0][31:0]        res_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (in_side.is_floor) begin
            n1_in[i] = (i == 2) ? $signed({1'b0, ONE}) : '0;
         end else if (in_side.degen) begin
            n1_in[i] = '0;
         end else if (in_side.neg[i]) begin
            n1_in[i] = -$signed({1'b0, in_nq[i]});
         end else begin
            n1_in[i] = $signed({1'b0, in_nq[i]});
         end
      end
      ra1_in = in_side.is_floor ? ONE : (in_side.degen ? '0 : in_ra);
      rb1_in = (in_side.is_floor || in_side.degen) ? '0 : in_rb;
   end

   always_comb begin
      logic signed [SUMW-1:0] sum;
      sum = SUMW'(pv2_ff[0]) + SUMW'(pv2_ff[1]) + SUMW'(pv2_ff[2]);
      if (fl2_ff) begin
         s3_in = pcr_pkg::S_W'($signed(vz2_ff));
      end else begin
         s3_in = pcr_pkg::S_W'(sum >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff   <= n1_in;
         ra1_ff  <= ra1_in;
         rb1_ff  <= rb1_in;
         fl1_ff  <= in_side.is_floor;
         vel1_ff <= in_side.vel;
         dep1_ff <= in_side.depth;

         for (int i = 0; i < 3; i++) begin
            pv2_ff[i] <= $signed(vel1_ff[i]) * n1_ff[i];
            pd2_ff[i] <= $signed(dep1_ff) * n1_ff[i];
         end
         n2_ff  <= n1_ff;
         ra2_ff <= ra1_ff;
         rb2_ff <= rb1_ff;
         fl2_ff <= fl1_ff;
         vz2_ff <= vel1_ff[2];

         s3_ff <= s3_in;
         for (int i = 0; i < 3; i++) begin
            p3_ff[i] <= pcr_pkg::P_W'(pd2_ff[i] >>> FRAC_BITS);
         end
         n3_ff  <= n2_ff;
         ra3_ff <= ra2_ff;
         rb3_ff <= rb2_ff;

         es4_ff <= $signed({1'b0, restitution}) * s3_ff;
         for (int i = 0; i < 3; i++) begin
            pa4_ff[i] <= $signed({1'b0, ra3_ff}) * p3_ff[i];
            pb4_ff[i] <= $signed({1'b0, rb3_ff}) * p3_ff[i];
         end
         n4_ff  <= n3_ff;
         ra4_ff <= ra3_ff;
         rb4_ff <= rb3_ff;

         k5_ff <= pcr_pkg::K_W'((-es4_ff) >>> 15);
         for (int i = 0; i < 3; i++) begin
            dpa5_ff[i] <= pcr_pkg::sat32(64'(pa4_ff[i] >>> FRAC_BITS));
            dpb5_ff[i] <= pcr_pkg::sat32(64'((-pb4_ff[i]) >>> FRAC_BITS));
         end
         n5_ff  <= n4_ff;
         ra5_ff <= ra4_ff;
         rb5_ff <= rb4_ff;

         for (int i = 0; i < 3; i++) begin
            kn6_ff[i] <= k5_ff * n5_ff[i];
         end
         ra6_ff  <= ra5_ff;
         rb6_ff  <= rb5_ff;
         dpa6_ff <= dpa5_ff;
         dpb6_ff <= dpb5_ff;

         for (int i = 0; i < 3; i++) begin
            vs7_ff[i] <= pcr_pkg::K_W'(kn6_ff[i] >>> FRAC_BITS);
         end
         ra7_ff  <= ra6_ff;
         rb7_ff  <= rb6_ff;
         dpa7_ff <= dpa6_ff;
         dpb7_ff <= dpb6_ff;

         for (int i = 0; i < 3; i++) begin
            av8_ff[i] <= $signed({1'b0, ra7_ff}) * vs7_ff[i];
            bv8_ff[i] <= $signed({1'b0, rb7_ff}) * vs7_ff[i];
         end
         dpa8_ff <= dpa7_ff;
         dpb8_ff <= dpb7_ff;

         // impulse factor of two folded in as a left shift
         for (int i = 0; i < 3; i++) begin
            res_ff[i]     <= pcr_pkg::sat32((64'(av8_ff[i]) <<< 1) >>> FRAC_BITS);
            res_ff[3 + i] <= pcr_pkg::sat32((-(64'(bv8_ff[i]) <<< 1)) >>> FRAC_BITS);
            res_ff[6 + i] <= dpa8_ff[i];
            res_ff[9 + i] <= dpb8_ff[i];
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_data  = res_ff;

endmodule

`default_nettype wire

@@ rtl/particle_contact_resolver_unit.sv @@
// Path from req accept to rsp valid:
//   3 front stages, 32 square-root stages, FRAC_BITS + 1 divider stages, 9 back stages.
// Throughput: one contact per cycle while no held rsp stalls it; every stage holds its own transaction.
// A held rsp stalls the whole pipeline in place; req_tready drops only then.
// Reset (synchronous, active high) empties the pipeline and sets restitution to 1.0.
`default_nettype none

module particle_contact_resolver_unit #(
   parameter int FRAC_BITS = pcr_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z,
   //        inv_mass_a, inv_mass_b, depth (32 bits each, lowest first)
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pcr_pkg::IN_DATA_W-1:0]     req_tdata,
   input  logic                              req_tuser,   // is_floor
   // tdata: dvel_a_x/y/z, dvel_b_x/y/z, dpos_a_x/y/z, dpos_b_x/y/z (32 bits each)
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pcr_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pcr_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int QW      = FRAC_BITS + 1;
   localparam int DW      = 32 + FRAC_BITS;
   localparam int LANES   = 5;
   localparam int GEOM_W  = $bits(pcr_pkg::geom_type);
   localparam int BACK_W  = $bits(pcr_pkg::back_type);

   logic                       en;
   logic [15:0]                restitution_ff;
   logic                       csr_wr;

   logic [2:0][31:0]           pos, vel;
   logic                       f_valid;
   pcr_pkg::geom_type          f_geom;
   logic [63:0]                f_sq;

   logic                       q_valid;
   logic [31:0]                q_root;
   logic [GEOM_W-1:0]          q_side;
   pcr_pkg::geom_type          q_geom;

   logic [LANES-1:0][DW-1:0]   d_num;
   logic [LANES-1:0][32:0]     d_den;
   pcr_pkg::back_type          d_side_in;
   logic                       d_valid;
   logic [LANES-1:0][QW-1:0]   d_quo;
   logic [BACK_W-1:0]          d_side;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == pcr_pkg::ADDR_RESTITUTION);
   assign csr_prdata = (csr_paddr == pcr_pkg::ADDR_RESTITUTION) ?
                       {16'b0, restitution_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= pcr_pkg::RESTITUTION_RST;
      end else if (csr_wr) begin
         restitution_ff <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos[i] = req_tdata[32*i +: 32];
         vel[i] = req_tdata[32*(3+i) +: 32];
      end
   end

   pcr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_tvalid && req_tready),
      .in_is_floor (req_tuser),
      .in_pos      (pos),
      .in_vel      (vel),
      .in_inv_a    (req_tdata[223:192]),
      .in_inv_b    (req_tdata[255:224]),
      .in_depth    (req_tdata[287:256]),
      .out_valid   (f_valid),
      .out_geom    (f_geom),
      .out_sq_sum  (f_sq)
   );

   pcr_isqrt #(.SIDE_W(GEOM_W)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_rad    (f_sq),
      .in_side   (f_geom),
      .out_valid (q_valid),
      .out_root  (q_root),
      .out_side  (q_side)
   );

   assign q_geom = q_side;

   // normal components over the length, then the two mass ratios over the sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_num[i] = DW'(q_geom.mag[i]) << FRAC_BITS;
         d_den[i] = {1'b0, q_root};
      end
      d_num[3] = DW'(q_geom.inv_a) << FRAC_BITS;
      d_den[3] = q_geom.mass_sum;
      d_num[4] = DW'(q_geom.inv_b) << FRAC_BITS;
      d_den[4] = q_geom.mass_sum;

      d_side_in.is_floor = q_geom.is_floor;
      d_side_in.degen    = (q_root == '0) || (q_geom.mass_sum == '0);
      d_side_in.neg      = q_geom.neg;
      d_side_in.vel      = q_geom.vel;
      d_side_in.depth    = q_geom.depth;
   end

   pcr_div #(
      .LANES  (LANES),
      .DW     (DW),
      .VW     (33),
      .QW     (QW),
      .SIDE_W (BACK_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (q_valid),
      .in_num    (d_num),
      .in_den    (d_den),
      .in_side   (d_side_in),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_side  (d_side)
   );

   pcr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (d_valid),
      .in_side     (d_side),
      .in_nq       (d_quo[2:0]),
      .in_ra       (d_quo[3]),
      .in_rb       (d_quo[4]),
      .restitution (restitution_ff),
      .out_valid   (rsp_tvalid),
      .out_data    (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ rtl/pcr_checker.sv @@
`default_nettype none

module pcr_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tready,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [pcr_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pcr_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   input  logic [31:0]                       csr_prdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   a_stall_only_on_held_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tready == !(rsp_tvalid && !rsp_tready))
      else $error("req_tready does not follow output stall");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr == pcr_pkg::ADDR_RESTITUTION
      |=> csr_paddr != pcr_pkg::ADDR_RESTITUTION
          || csr_prdata == {16'b0, $past(csr_pwdata[15:0])})
      else $error("restitution readback mismatch");

endmodule

bind particle_contact_resolver_unit pcr_checker u_pcr_checker (.*);

`default_nettype wire
